[rtl/dlp_pkg.sv]
// Shared types and constants of the decimal list field parser.
package dlp_pkg;

  localparam int VALUE_W = 63;
  localparam int COUNT_W = 7;
  localparam int CHAR_W  = 8;

  localparam logic [CHAR_W-1:0]  SEPARATOR = 8'h3B;
  localparam logic [CHAR_W-1:0]  DIGIT_0   = 8'h30;
  localparam logic [CHAR_W-1:0]  DIGIT_9   = 8'h39;
  localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = 63'd4294967295;

  // Result queue geometry
  localparam int RES_DEPTH = 4;
  localparam int RES_AW    = 2;

  typedef enum logic {
    KIND_VALUE   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    REASON_END  = 2'd0,
    REASON_BAD  = 2'd1,
    REASON_FULL = 2'd2
  } reason_t;

  typedef struct packed {
    kind_t                kind;
    logic [VALUE_W-1:0]   value;
    logic [COUNT_W-1:0]   index;
    reason_t              reason;
    logic                 last;
  } result_t;

  // Up to two results produced by one request, in order
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

[rtl/dlp_stream_if.sv]
// Request and result channel interfaces of the decimal list field parser.
interface dlp_in_if import dlp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_text;

  modport source (output valid, char_code, end_of_text, input ready);
  modport sink   (input valid, char_code, end_of_text, output ready);
endinterface

interface dlp_out_if import dlp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [VALUE_W-1:0] field_value;
  logic [COUNT_W-1:0] field_index;
  logic [1:0]         finish_reason;
  logic               run_last;

  modport source (output valid, result_kind, field_value, field_index, finish_reason,
                  run_last, input ready);
  modport sink   (input valid, result_kind, field_value, field_index, finish_reason,
                  run_last, output ready);
endinterface

[rtl/decimal_list_field_parser.sv]
// Top level of the decimal list field parser: core, result queue, channel glue.
// Results are registered in the result queue and offered from its head on the result channel.
// Throughput: one character request per cycle while ready is high; a request may yield up to two results.
// Ready drops while the result queue holds more than RES_DEPTH-2 results.
// Reset (rst, synchronous, active high): parse state cleared, queue emptied,
// max_value back to 4294967295.
module decimal_list_field_parser import dlp_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  logic               clk,
  input  logic               rst,
  dlp_in_if.sink             char_in,
  dlp_out_if.source          result_out,
  input  logic               cfg_we,
  input  logic [VALUE_W-1:0] cfg_data
);

  push_t           push;
  result_t         head;
  logic            not_empty;
  logic [RES_AW:0] level;
  logic            accept;
  logic            pop;

  // A request is taken only when the queue has room for the two results
  // it can produce at most; this keeps the core free of any stall path.
  assign char_in.ready = (level <= (RES_AW+1)'(RES_DEPTH - 2));
  assign accept        = char_in.valid && char_in.ready;
  assign pop           = result_out.valid && result_out.ready;

  // Core: per-character state update and combinational result build.
  dlp_core #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .char_code   (char_in.char_code),
    .end_of_text (char_in.end_of_text),
    .push        (push)
  );

  // Queue registers every result; the output side reads its head.
  dlp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .level     (level)
  );

  assign result_out.valid         = not_empty;
  assign result_out.result_kind   = head.kind;
  assign result_out.field_value   = head.value;
  assign result_out.field_index   = head.index;
  assign result_out.finish_reason = head.reason;
  assign result_out.run_last      = head.last;

  // Queue never overfills
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= (RES_AW+1)'(RES_DEPTH))
    else $error("result queue overfilled");

  // A pair of results is always value then summary, last flag on the second
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.num == 2'd2 |-> push.first.kind == KIND_VALUE && push.second.kind == KIND_SUMMARY
                         && !push.first.last && push.second.last)
    else $error("bad result pair");

  // Nothing is produced without a taken request
  a_push_needs_req: assert property (@(posedge clk) disable iff (rst)
    !accept |-> push.num == 2'd0)
    else $error("result without request");

  // Value results carry zero reason; summaries carry zero value
  a_kind_fields: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> (head.kind == KIND_VALUE && head.reason == REASON_END)
                         || (head.kind == KIND_SUMMARY && head.value == '0))
    else $error("result fields inconsistent with kind");

endmodule

[rtl/dlp_core.sv]
// Parse state, limit register and per-character result generation.
module dlp_core import dlp_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [VALUE_W-1:0] cfg_data,
  input  logic               accept,
  input  logic [CHAR_W-1:0]  char_code,
  input  logic               end_of_text,
  output push_t              push
);

  logic [VALUE_W-1:0] max_value;
  logic [VALUE_W-1:0] acc, acc_next;
  logic               seen, seen_next;
  logic               ended, ended_next;
  logic               invalid, invalid_next;
  logic [COUNT_W-1:0] count, count_next;
  logic               stopped, stopped_next;

  logic               is_sep, is_digit, good;
  logic [COUNT_W-1:0] count_inc;
  logic [VALUE_W+3:0] scaled;   // acc*10 + digit, never wraps

  assign is_sep    = end_of_text || (char_code == SEPARATOR);
  assign is_digit  = (char_code >= DIGIT_0) && (char_code <= DIGIT_9);
  assign good      = seen && !invalid;
  assign count_inc = count + COUNT_W'(1);
  assign scaled    = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
                   + {{VALUE_W{1'b0}}, char_code[3:0]};

  always_comb begin
    acc_next     = acc;
    seen_next    = seen;
    ended_next   = ended;
    invalid_next = invalid;
    count_next   = count;
    stopped_next = stopped;
    push         = '0;

    if (accept) begin
      priority if (stopped) begin
        if (end_of_text) begin
          acc_next     = '0;
          seen_next    = 1'b0;
          ended_next   = 1'b0;
          invalid_next = 1'b0;
          count_next   = '0;
          stopped_next = 1'b0;
        end
      end else if (is_sep) begin
        if (good) begin
          push.first.kind  = KIND_VALUE;
          push.first.value = acc;
          push.first.index = count;
          count_next       = count_inc;
          push.second.kind  = KIND_SUMMARY;
          push.second.index = count_inc;
          push.second.last  = 1'b1;
          if (end_of_text) begin
            push.num           = 2'd2;
            push.second.reason = REASON_END;
          end else if (count_inc >= COUNT_W'(MAX_ITEMS)) begin
            push.num           = 2'd2;
            push.second.reason = REASON_FULL;
            stopped_next       = 1'b1;
          end else begin
            push.num        = 2'd1;
            push.first.last = 1'b1;
          end
        end else begin
          push.num          = 2'd1;
          push.first.kind   = KIND_SUMMARY;
          push.first.index  = count;
          push.first.reason = REASON_BAD;
          push.first.last   = 1'b1;
          stopped_next      = 1'b1;
        end
        acc_next     = '0;
        seen_next    = 1'b0;
        ended_next   = 1'b0;
        invalid_next = 1'b0;
        if (end_of_text) begin
          count_next   = '0;
          stopped_next = 1'b0;
        end
      end else if (is_digit) begin
        if (!ended && !invalid) begin
          seen_next = 1'b1;
          if (scaled > {4'b0000, max_value}) begin
            invalid_next = 1'b1;
          end else begin
            acc_next = scaled[VALUE_W-1:0];
          end
        end
      end else begin
        if (!seen) begin
          invalid_next = 1'b1;
        end else begin
          ended_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_value <= MAX_VALUE_RESET;
      acc       <= '0;
      seen      <= 1'b0;
      ended     <= 1'b0;
      invalid   <= 1'b0;
      count     <= '0;
      stopped   <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_value <= cfg_data;
      end
      acc     <= acc_next;
      seen    <= seen_next;
      ended   <= ended_next;
      invalid <= invalid_next;
      count   <= count_next;
      stopped <= stopped_next;
    end
  end

endmodule

[rtl/dlp_fifo.sv]
// Result queue: takes up to two results per cycle, hands out one.
module dlp_fifo import dlp_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  push_t           push,
  input  logic            pop,
  output result_t         head,
  output logic            not_empty,
  output logic [RES_AW:0] level
);

  result_t           mem [RES_DEPTH];
  logic [RES_AW-1:0] wr_ptr;
  logic [RES_AW-1:0] rd_ptr;

  assign head      = mem[rd_ptr];
  assign not_empty = (level != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_AW'(push.num);
      if (pop) begin
        rd_ptr <= rd_ptr + RES_AW'(1);
      end
      level <= level + (RES_AW+1)'(push.num) - (RES_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr + RES_AW'(1)] <= push.second;
    end
  end

endmodule

[tb/tb.sv]
// Testbench of decimal_list_field_parser: random and directed character lists, checked per result.
`timescale 1ns / 1ps

module tb;
  import dlp_pkg::*;

  // ---------------------------------------------------------------------------
  // Run shape
  // ---------------------------------------------------------------------------
  localparam int unsigned LIST_CAP          = 16;     // MAX_ITEMS of the block
  localparam int          NUM_PHASES        = 8;
  localparam int          ITEMS_PER_PHASE   = 200;    // at least 1600 requests over the run
  localparam int          RESET_CYCLES      = 12;
  localparam int          CFG_SETTLE        = 4;      // margin before a register write
  localparam int          END_SETTLE        = 8;
  localparam int          LONG_STALL_PHASE  = 4;      // a phase with no random idling
  localparam int          LONG_STALL_CYCLES = 200;
  localparam longint      RUN_LIMIT_NS      = 2_000_000;

  // Idle percentages of the four idling modes, selected by phase number mod 4:
  // none, sender only, receiver only, both.
  localparam int SEND_IDLE [4] = '{0, 63, 0, 38};
  localparam int RECV_IDLE [4] = '{0, 0, 63, 38};

  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
  localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;

  typedef struct {
    logic [CHAR_W-1:0] char_code;
    logic              end_of_text;
  } char_req_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and the block
  // ---------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [VALUE_W-1:0] cfg_data;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dlp_in_if  char_in ();
  dlp_out_if result_out ();

  decimal_list_field_parser #(
    .MAX_ITEMS(LIST_CAP)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_in),
    .result_out(result_out),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Queues and bookkeeping
  // ---------------------------------------------------------------------------
  char_req_t pending_chars [$];      // requests still to be offered, head is on the bus
  result_t   expected_results [$];   // predicted results not yet seen

  bit offer_live    = 1'b0;          // head of pending_chars is driven and not yet taken
  bit rx_hold       = 1'b0;          // long receiver hold-off in progress
  bit long_stall_go = 1'b0;
  int sender_idle_pct = 0;
  int rx_stall_pct    = 0;

  int fail_count     = 0;
  int queued_count   = 0;
  int chars_accepted = 0;
  int values_seen    = 0;
  int summaries_seen [3] = '{0, 0, 0};
  int limit_writes   = 0;

  // ---------------------------------------------------------------------------
  // Parser model: own copy of the register and of the parse state
  // ---------------------------------------------------------------------------
  logic [VALUE_W-1:0] max_value_cfg;
  logic [VALUE_W-1:0] acc_value;
  bit                 seen_digit;    // field has had at least one digit
  bit                 digits_done;   // a non-digit closed the number part
  bit                 field_bad;     // leading non-digit or overflow
  logic [COUNT_W-1:0] values_emitted;
  bit                 list_halted;   // list stopped: ignore until end of text

  function automatic void clear_field();
    acc_value   = '0;
    seen_digit  = 1'b0;
    digits_done = 1'b0;
    field_bad   = 1'b0;
  endfunction

  function automatic void clear_list();
    clear_field();
    values_emitted = '0;
    list_halted    = 1'b0;
  endfunction

  function automatic result_t make_result(kind_t k, logic [VALUE_W-1:0] v,
                                          logic [COUNT_W-1:0] idx, reason_t why);
    result_t r;
    r.kind   = k;
    r.value  = v;
    r.index  = idx;
    r.reason = why;
    r.last   = 1'b0;
    return r;
  endfunction

  // Runs one accepted character through the model and queues what it yields.
  function automatic void parse_char(logic [CHAR_W-1:0] ch, logic eot);
    result_t     outs [2];
    int          n;
    logic [63:0] lim;
    logic [63:0] d;
    bit          good;
    n   = 0;
    lim = {1'b0, max_value_cfg};
    if (list_halted) begin
      // stopped list: only end of text matters, and it yields nothing
      if (eot) clear_list();
      return;
    end
    if (eot || ch == SEPARATOR) begin
      good = seen_digit && !field_bad;
      if (good) begin
        outs[n] = make_result(KIND_VALUE, acc_value, values_emitted, REASON_END);
        n = n + 1;
        values_emitted = values_emitted + 1'b1;
        if (eot) begin
          // end of text wins over a full list
          outs[n] = make_result(KIND_SUMMARY, '0, values_emitted, REASON_END);
          n = n + 1;
        end else if (values_emitted >= LIST_CAP) begin
          outs[n] = make_result(KIND_SUMMARY, '0, values_emitted, REASON_FULL);
          n = n + 1;
          list_halted = 1'b1;
        end
      end else begin
        // empty field, leading non-digit or overflow stops the list
        outs[n] = make_result(KIND_SUMMARY, '0, values_emitted, REASON_BAD);
        n = n + 1;
        list_halted = 1'b1;
      end
      if (eot) clear_list();
      else clear_field();
    end else if (ch >= DIGIT_0 && ch <= DIGIT_9) begin
      if (!digits_done && !field_bad) begin
        d          = 64'(ch - DIGIT_0);
        seen_digit = 1'b1;
        // would the next value pass max_value? then the field is bad
        if (d > lim || 64'(acc_value) > (lim - d) / 10) field_bad = 1'b1;
        else acc_value = VALUE_W'(64'(acc_value) * 10 + d);
      end
    end else begin
      if (!seen_digit) field_bad = 1'b1;
      else digits_done = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) outs[i].last = 1'b1;
      expected_results.push_back(outs[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_request(logic [CHAR_W-1:0] ch, logic eot);
    char_req_t q;
    q.char_code   = ch;
    q.end_of_text = eot;
    pending_chars.push_back(q);
    queued_count++;
  endfunction

  // char_code is don't-care on end of text, so it is random there
  function automatic void push_eot();
    push_request(CHAR_W'($urandom_range(0, 255)), 1'b1);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_request(s[i], 1'b0);
  endfunction

  function automatic void push_value_text(logic [63:0] v, int zeros);
    repeat (zeros) push_request(DIGIT_0, 1'b0);
    push_text($sformatf("%0d", v));
  endfunction

  // Any byte but the separator; digits only when allowed.
  function automatic logic [CHAR_W-1:0] pick_char(bit allow_digits);
    logic [CHAR_W-1:0] c;
    do begin
      c = CHAR_W'($urandom_range(0, 255));
    end while (c == SEPARATOR || (!allow_digits && c >= DIGIT_0 && c <= DIGIT_9));
    return c;
  endfunction

  // A field that fits max_value, biased to the limits, sometimes with
  // leading zeros or trailing junk after the number.
  function automatic void gen_good_field();
    logic [63:0] lim;
    logic [63:0] v;
    int          r;
    lim = {1'b0, max_value_cfg};
    r   = $urandom_range(0, 99);
    if (r < 15) v = 0;
    else if (r < 30) v = lim;
    else if (r < 40) v = (lim == 0) ? 64'd0 : lim - 1;
    else if (r < 70) v = 64'($urandom_range(0, 999)) % (lim + 1);
    else v = {$urandom, $urandom} % (lim + 1);
    push_value_text(v, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
    if ($urandom_range(0, 6) == 0) begin
      push_request(pick_char(1'b0), 1'b0);
      repeat ($urandom_range(0, 3)) push_request(pick_char(1'b1), 1'b0);
    end
  endfunction

  // A field that must stop the list: empty, signed, junk first, or too big.
  function automatic void gen_bad_field();
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        push_request($urandom_range(0, 1) ? MINUS_CHAR : PLUS_CHAR, 1'b0);
        push_value_text(64'($urandom_range(0, 99999)), 0);
      end
      2: begin
        push_request(pick_char(1'b0), 1'b0);
        repeat ($urandom_range(0, 3)) push_request(pick_char(1'b1), 1'b0);
      end
      default: begin
        if ($urandom_range(0, 1)) begin
          push_value_text({1'b0, max_value_cfg} + 64'd1, $urandom_range(0, 2));
        end else begin
          // twenty digits are always above the 63-bit range
          push_request(DIGIT_0 + CHAR_W'($urandom_range(1, 9)), 1'b0);
          repeat (19) push_request(DIGIT_0 + CHAR_W'($urandom_range(0, 9)), 1'b0);
        end
      end
    endcase
  endfunction

  // One list, mostly well formed; a few are pure noise with stray ends of text.
  function automatic void gen_list();
    int nfields;
    int r;
    bit bad;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(4, 12))
        push_request(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      push_eot();
      return;
    end
    // short lists, lists around the item cap, and middle sizes
    nfields = (r < 50) ? $urandom_range(1, 5) :
              (r < 80) ? $urandom_range(14, 18) : $urandom_range(6, 13);
    for (int i = 0; i < nfields; i++) begin
      bad = ($urandom_range(0, 99) < 5);
      if (bad) gen_bad_field();
      else gen_good_field();
      if (i == nfields - 1) break;
      push_request(SEPARATOR, 1'b0);
      if (bad) begin
        // list has stopped; a little text that must be ignored
        repeat ($urandom_range(0, 3)) push_request(pick_char(1'b1), 1'b0);
        break;
      end
    end
    if ($urandom_range(0, 9) == 0) push_request(SEPARATOR, 1'b0);  // empty last field
    push_eot();
  endfunction

  // Sender pause: wait until every request is taken and every result seen.
  task automatic drain();
    while (pending_chars.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  // Register write while the block is idle.
  task automatic write_max_value(logic [VALUE_W-1:0] v);
    drain();
    repeat (CFG_SETTLE) @(negedge clk);
    cfg_we        <= 1'b1;
    cfg_data      <= v;
    max_value_cfg  = v;
    limit_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: changes at the falling edge, holds a request until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : char_driver
    if (!offer_live) begin
      if (!rst && pending_chars.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        char_in.valid       <= 1'b1;
        char_in.char_code   <= pending_chars[0].char_code;
        char_in.end_of_text <= pending_chars[0].end_of_text;
        offer_live           = 1'b1;
      end else begin
        // idle cycle: payload is junk the block must not take
        char_in.valid       <= 1'b0;
        char_in.char_code   <= CHAR_W'($urandom_range(0, 255));
        char_in.end_of_text <= 1'($urandom_range(0, 1));
      end
    end
  end

  // Result receiver: random stalls plus the long hold-off.
  always @(negedge clk) begin : result_ready_driver
    result_out.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Long hold-off, counted here while the sender keeps offering.
  initial begin : long_stall
    wait (long_stall_go);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (LONG_STALL_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: rising-edge sampling of both handshakes
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst && char_in.valid && char_in.ready) begin
      // predict first: the results of this request can only come later
      parse_char(char_in.char_code, char_in.end_of_text);
      void'(pending_chars.pop_front());
      offer_live = 1'b0;
      chars_accepted++;
    end
    if (!rst && result_out.valid && result_out.ready) begin
      if (expected_results.size() == 0) begin
        $error("result with none expected: kind %0d value %0d index %0d reason %0d",
               result_out.result_kind, result_out.field_value, result_out.field_index,
               result_out.finish_reason);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind",   want.kind,   result_out.result_kind);
        check_field("field_value",   want.value,  result_out.field_value);
        check_field("field_index",   want.index,  result_out.field_index);
        check_field("finish_reason", want.reason, result_out.finish_reason);
        check_field("run_last",      want.last,   result_out.run_last);
      end
      if (result_out.result_kind == KIND_VALUE) values_seen++;
      else if (result_out.finish_reason <= REASON_FULL)
        summaries_seen[result_out.finish_reason]++;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed lists, then phases of random lists, each
  // under its own max_value and idling mode
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [VALUE_W-1:0] phase_limits [NUM_PHASES];
    int                 batch_start;
    bit                 paused;
    char_in.valid       = 1'b0;
    char_in.char_code   = '0;
    char_in.end_of_text = 1'b0;
    result_out.ready    = 1'b0;
    cfg_we              = 1'b0;
    cfg_data            = '0;
    rst                 = 1'b1;
    max_value_cfg       = MAX_VALUE_RESET;
    clear_list();

    phase_limits = '{MAX_VALUE_RESET, '0, '1, 63'd99, 63'd65535,
                     63'd1_000_000_000_000_000_000, '0, 63'd9};
    phase_limits[6] = VALUE_W'({$urandom, $urandom} >> $urandom_range(1, 62));

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) write_max_value(phase_limits[p]);
      sender_idle_pct = SEND_IDLE[p % 4];
      rx_stall_pct    = RECV_IDLE[p % 4];
      if (p == LONG_STALL_PHASE) long_stall_go = 1'b1;

      if (p == 0) begin
        // good fields, a field closed by a non-digit, value then end of text,
        // bare end of text, signs, a junk first byte, an empty field
        push_text("0;");
        push_text("9");
        push_request(8'hFF, 1'b0);
        push_text(";5");
        push_eot();
        push_eot();
        push_text("-1;2");
        push_eot();
        push_request(PLUS_CHAR, 1'b0);
        push_eot();
        push_request(8'h00, 1'b0);
        push_text(";");
        push_eot();
        push_text(";");
        push_eot();
      end else if (p == 1) begin
        // max_value of zero: only zero fits, the digit one overflows
        push_text("00;1;");
        push_eot();
      end else if (p == 2) begin
        // full 63-bit range and one past it
        push_text("9223372036854775807;9223372036854775808;");
        push_eot();
      end

      batch_start = queued_count;
      paused      = 1'b0;
      while (queued_count - batch_start < ITEMS_PER_PHASE) begin
        gen_list();
        if (!paused && queued_count - batch_start >= ITEMS_PER_PHASE / 2) begin
          drain();
          paused = 1'b1;
        end
      end
      drain();
    end

    repeat (END_SETTLE) @(negedge clk);
    $display("covered %0d characters under %0d max_value writes: %0d values returned",
             chars_accepted, limit_writes, values_seen);
    $display("lists ended by end of text %0d, by a bad field %0d, by a full list %0d",
             summaries_seen[REASON_END], summaries_seen[REASON_BAD],
             summaries_seen[REASON_FULL]);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("timeout: %0d requests queued, %0d results outstanding",
             pending_chars.size(), expected_results.size());
    $display("status: fail");
    $finish;
  end

endmodule
